[hdl/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[hdl/plcg_pkg.sv]
package plcg_pkg;

    localparam int POS_W     = 17;
    localparam int CNT_W     = 3;
    localparam int COLOR_W   = 24;
    localparam int CH_W      = 8;
    localparam int NUM_CH    = 3;
    localparam int NUM_SEGS  = 6;
    localparam int SEG_W     = 3;
    localparam int SCALED_W  = 19;
    localparam int FRAC_W    = 17;
    localparam int PROD_W    = 25;
    localparam int IDX_W     = 4;
    localparam int LATENCY   = 4;

    localparam logic [POS_W-1:0]  ONE_Q16   = 17'h10000;
    localparam logic [PROD_W-1:0] PROD_MAX  = 25'(255 * 65536);
    localparam logic [PROD_W:0]   ROUND_BIAS = 26'h8000;

    localparam logic [IDX_W-1:0] REG_STOP_COUNT   = 4'd0;
    localparam logic [IDX_W-1:0] REG_STOP_COLOR_0 = 4'd1;

    localparam logic [CNT_W-1:0]   RST_STOP_COUNT = 3'd2;
    localparam logic [COLOR_W-1:0] COLOR_BLACK    = 24'h000000;
    localparam logic [COLOR_W-1:0] COLOR_WHITE    = 24'hFFFFFF;

    typedef logic [COLOR_W-1:0] t_color;

    typedef struct packed {
        logic [CNT_W-1:0]              count;
        logic [NUM_SEGS-1:0][COLOR_W-1:0] lo;
        logic [NUM_SEGS-1:0][COLOR_W-1:0] hi;
    } t_palette;

    typedef struct packed {
        logic              valid;
        t_color            c0;
        t_color            c1;
        logic [FRAC_W-1:0] frac;
    } t_seg_data;

endpackage

[hdl/plcg_cfg.sv]
module plcg_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    input  logic [plcg_pkg::IDX_W-1:0]  i_cfg_index,
    input  logic [plcg_pkg::COLOR_W-1:0] i_cfg_data,
    output plcg_pkg::t_palette          o_palette
);

    plcg_pkg::t_palette r_pal;
    plcg_pkg::t_palette n_pal;

    // Each inner stop color is kept twice: as the lower end of one segment and as the
    // upper end of the previous one, so each copy is read at a single address.
    always_comb begin
        n_pal = r_pal;
        if (i_cfg_valid) begin
            if (i_cfg_index == plcg_pkg::REG_STOP_COUNT) begin
                n_pal.count = i_cfg_data[plcg_pkg::CNT_W-1:0];
            end
            for (int j = 0; j < plcg_pkg::NUM_SEGS; j++) begin
                if (i_cfg_index == plcg_pkg::REG_STOP_COLOR_0 + plcg_pkg::IDX_W'(j)) begin
                    n_pal.lo[j] = i_cfg_data;
                end
                if (i_cfg_index == plcg_pkg::REG_STOP_COLOR_0 + plcg_pkg::IDX_W'(j + 1)) begin
                    n_pal.hi[j] = i_cfg_data;
                end
            end
        end
    end

    // The second stop resets to white; it is the upper end of segment 0 and
    // the lower end of segment 1.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pal.count <= plcg_pkg::RST_STOP_COUNT;
            for (int j = 0; j < plcg_pkg::NUM_SEGS; j++) begin
                r_pal.lo[j] <= (j == 1) ? plcg_pkg::COLOR_WHITE : plcg_pkg::COLOR_BLACK;
                r_pal.hi[j] <= (j == 0) ? plcg_pkg::COLOR_WHITE : plcg_pkg::COLOR_BLACK;
            end
        end else begin
            r_pal <= n_pal;
        end
    end

    assign o_palette = r_pal;

endmodule

[hdl/plcg_seg.sv]
`include "assert_macros.svh"

module plcg_seg (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  logic [plcg_pkg::POS_W-1:0] i_position,
    input  plcg_pkg::t_palette         i_palette,
    output plcg_pkg::t_seg_data        o_seg
);

    logic                          r1_valid;
    logic [plcg_pkg::SCALED_W-1:0] r1_scaled;
    logic [plcg_pkg::CNT_W-1:0]    r1_nm1;

    logic [plcg_pkg::POS_W-1:0]    pos_sat;
    logic [plcg_pkg::CNT_W-1:0]    nm1;
    logic [plcg_pkg::SCALED_W-1:0] n1_scaled;

    logic [plcg_pkg::SEG_W-1:0]    seg_raw;
    logic [plcg_pkg::SEG_W-1:0]    seg_last;
    logic [plcg_pkg::SEG_W-1:0]    seg;
    logic [plcg_pkg::SCALED_W-1:0] frac_wide;

    plcg_pkg::t_seg_data           r_seg;
    plcg_pkg::t_seg_data           n_seg;

    always_comb begin
        pos_sat = (i_position > plcg_pkg::ONE_Q16) ? plcg_pkg::ONE_Q16 : i_position;
        nm1 = (i_palette.count == '0) ? '0 : i_palette.count - 1'b1;
        n1_scaled = plcg_pkg::SCALED_W'(pos_sat) * plcg_pkg::SCALED_W'(nm1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else begin
            r1_valid <= i_valid;
        end
        r1_scaled <= n1_scaled;
        r1_nm1    <= nm1;
    end

    always_comb begin
        seg_raw  = r1_scaled[plcg_pkg::SCALED_W-1:16];
        seg_last = r1_nm1 - 1'b1;
        if (r1_nm1 == '0) begin
            seg = '0;
        end else if (seg_raw > seg_last) begin
            seg = seg_last;
        end else begin
            seg = seg_raw;
        end
        frac_wide = r1_scaled - {seg, 16'h0000};

        n_seg.valid = r1_valid;
        n_seg.c0    = i_palette.lo[seg];
        if (r1_nm1 == '0) begin
            n_seg.c1   = i_palette.lo[seg];
            n_seg.frac = '0;
        end else begin
            n_seg.c1   = i_palette.hi[seg];
            n_seg.frac = frac_wide[plcg_pkg::FRAC_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg.valid <= 1'b0;
        end else begin
            r_seg.valid <= n_seg.valid;
        end
        r_seg.c0   <= n_seg.c0;
        r_seg.c1   <= n_seg.c1;
        r_seg.frac <= n_seg.frac;
    end

    assign o_seg = r_seg;

    `ASSERT_IMPL(a_frac_bound, i_clk, i_rst_n, r_seg.valid, r_seg.frac <= plcg_pkg::ONE_Q16)

endmodule

[hdl/plcg_lerp.sv]
`include "assert_macros.svh"

module plcg_lerp (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  plcg_pkg::t_seg_data       i_seg,
    output logic                      o_valid,
    output logic [plcg_pkg::CH_W-1:0] o_red,
    output logic [plcg_pkg::CH_W-1:0] o_green,
    output logic [plcg_pkg::CH_W-1:0] o_blue
);

    logic                        r_valid;
    logic [plcg_pkg::CH_W-1:0]   r_a    [plcg_pkg::NUM_CH];
    logic                        r_up   [plcg_pkg::NUM_CH];
    logic [plcg_pkg::PROD_W-1:0] r_prod [plcg_pkg::NUM_CH];

    logic [plcg_pkg::CH_W-1:0]   n_a    [plcg_pkg::NUM_CH];
    logic                        n_up   [plcg_pkg::NUM_CH];
    logic [plcg_pkg::PROD_W-1:0] n_prod [plcg_pkg::NUM_CH];

    logic                        r_out_valid;
    logic [plcg_pkg::CH_W-1:0]   r_out  [plcg_pkg::NUM_CH];
    logic [plcg_pkg::CH_W-1:0]   n_out  [plcg_pkg::NUM_CH];

    logic [plcg_pkg::CH_W-1:0]   ch_a   [plcg_pkg::NUM_CH];
    logic [plcg_pkg::CH_W-1:0]   ch_b   [plcg_pkg::NUM_CH];
    logic [plcg_pkg::CH_W-1:0]   ch_d   [plcg_pkg::NUM_CH];
    logic [plcg_pkg::PROD_W:0]   rounded [plcg_pkg::NUM_CH];
    logic [plcg_pkg::CH_W-1:0]   mag    [plcg_pkg::NUM_CH];

    // Lane 0 is red, taken from the top byte of the packed color.
    always_comb begin
        for (int k = 0; k < plcg_pkg::NUM_CH; k++) begin
            ch_a[k] = i_seg.c0[(plcg_pkg::NUM_CH-1-k)*plcg_pkg::CH_W +: plcg_pkg::CH_W];
            ch_b[k] = i_seg.c1[(plcg_pkg::NUM_CH-1-k)*plcg_pkg::CH_W +: plcg_pkg::CH_W];
            n_up[k] = (ch_b[k] >= ch_a[k]);
            ch_d[k] = n_up[k] ? (ch_b[k] - ch_a[k]) : (ch_a[k] - ch_b[k]);
            n_a[k]  = ch_a[k];
            n_prod[k] = plcg_pkg::PROD_W'(ch_d[k]) * plcg_pkg::PROD_W'(i_seg.frac);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_seg.valid;
        end
        for (int k = 0; k < plcg_pkg::NUM_CH; k++) begin
            r_a[k]    <= n_a[k];
            r_up[k]   <= n_up[k];
            r_prod[k] <= n_prod[k];
        end
    end

    always_comb begin
        for (int k = 0; k < plcg_pkg::NUM_CH; k++) begin
            rounded[k] = {1'b0, r_prod[k]} + plcg_pkg::ROUND_BIAS;
            mag[k]     = rounded[k][23:16];
            n_out[k]   = r_up[k] ? (r_a[k] + mag[k]) : (r_a[k] - mag[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= r_valid;
        end
        for (int k = 0; k < plcg_pkg::NUM_CH; k++) begin
            r_out[k] <= n_out[k];
        end
    end

    assign o_valid = r_out_valid;
    assign o_red   = r_out[0];
    assign o_green = r_out[1];
    assign o_blue  = r_out[2];

    `ASSERT_IMPL(a_prod_bound, i_clk, i_rst_n, r_valid, r_prod[0] <= plcg_pkg::PROD_MAX)
    `ASSERT_NEXT(a_valid_follow, i_clk, i_rst_n, r_valid, r_out_valid)

endmodule

[hdl/piecewise_linear_color_gradient.sv]
// Channel   Direction  Handshake                 Payload
// command   in         i_start / o_busy          i_position
// result    out        o_valid (one-cycle strobe) o_red, o_green, o_blue
// config    in         i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// One transaction is taken in every cycle; o_busy is always low.
// Each result passes through four register stages in order:
// scale by stop count, segment select, per-channel multiply, round and add.
// Reset is synchronous and active low; it clears the valid bits and loads the default palette.
// The receiver cannot stall, so the pipeline never holds.

`include "assert_macros.svh"

module piecewise_linear_color_gradient (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    output logic                         o_busy,
    input  logic [plcg_pkg::POS_W-1:0]   i_position,
    output logic                         o_valid,
    output logic [plcg_pkg::CH_W-1:0]    o_red,
    output logic [plcg_pkg::CH_W-1:0]    o_green,
    output logic [plcg_pkg::CH_W-1:0]    o_blue,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [plcg_pkg::IDX_W-1:0]   i_cfg_index,
    input  logic [plcg_pkg::COLOR_W-1:0] i_cfg_data
);

    plcg_pkg::t_palette  palette;
    plcg_pkg::t_seg_data seg_data;
    logic                accept;

    assign o_busy      = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign accept      = i_start & ~o_busy;

    plcg_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid & o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_palette   (palette)
    );

    plcg_seg u_seg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (accept),
        .i_position (i_position),
        .i_palette  (palette),
        .o_seg      (seg_data)
    );

    plcg_lerp u_lerp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_seg   (seg_data),
        .o_valid (o_valid),
        .o_red   (o_red),
        .o_green (o_green),
        .o_blue  (o_blue)
    );

    `ASSERT_IMPL(a_latency, i_clk, i_rst_n, o_valid, $past(accept, plcg_pkg::LATENCY))

endmodule
